>>> hw/rtl/bac_pkg.sv
`default_nettype none

package bac_pkg;

  // corners of the 2x2 source neighbourhood
  localparam int NUM_CORNERS = 4;
  localparam int CRN_TL = 0;
  localparam int CRN_BL = 1;
  localparam int CRN_TR = 2;
  localparam int CRN_BR = 3;

  // byte lanes of a pixel: blue, green, red, alpha from the low end
  localparam int NUM_CHANNELS = 4;
  localparam int NUM_COLOURS  = 3;
  localparam int CH_ALPHA     = 3;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [8:0]  ALPHA_ONE = 9'd256;

  // blend numerator, s*a2 + a1*d never exceeds 255*a0 < 2^16
  localparam int NUM_W = 16;

  // pipeline stage numbers, counted from the input
  localparam int STG_WGT    = 1;
  localparam int STG_PROD   = 2;
  localparam int STG_SMP    = 3;
  localparam int STG_CMP    = 4;
  localparam int STG_MUL    = 5;
  localparam int STG_SUM    = 6;
  localparam int STG_DIV0   = 7;
  localparam int DIV_STAGES = 8;
  localparam int STG_OUT    = STG_DIV0 + DIV_STAGES;
  localparam int NUM_STAGES = STG_OUT;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_ALPHA_CUT  = 1'b0,
    CFG_HIGH_ALPHA_CUT = 1'b1
  } bac_cfg_idx_t;

  localparam logic [7:0] LOW_CUT_RST  = 8'd5;
  localparam logic [7:0] HIGH_CUT_RST = 8'd250;

  typedef logic [7:0]                          bac_byte_t;
  typedef logic [16:0]                         bac_weight_t;
  typedef logic [NUM_CHANNELS-1:0][7:0]        bac_pixel_t;
  typedef logic [NUM_CORNERS-1:0][7:0]         bac_quad_byte_t;
  typedef logic [NUM_CORNERS-1:0][16:0]        bac_quad_weight_t;
  typedef logic [NUM_CORNERS-1:0][24:0]        bac_quad_prod_t;
  typedef logic [NUM_STAGES:1]                 bac_stage_t;

  // side data that travels beside the colour lanes
  typedef struct packed {
    bac_pixel_t sample;
    bac_pixel_t dest;
    bac_byte_t  alpha;
    logic       in_image;
    logic       replace;
    logic       zero;
  } bac_side_t;

endpackage

`default_nettype wire

>>> hw/rtl/bac_if.sv
`default_nettype none

interface bac_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frac_x;
  logic [15:0] frac_y;
  logic [31:0] pix_top_left;
  logic [31:0] pix_bottom_left;
  logic [31:0] pix_top_right;
  logic [31:0] pix_bottom_right;
  logic [31:0] dest_pixel;
  logic        inside_req;

  modport source (
    output valid, frac_x, frac_y, pix_top_left, pix_bottom_left,
           pix_top_right, pix_bottom_right, dest_pixel, inside_req,
    input  ready
  );
  modport sink (
    input  valid, frac_x, frac_y, pix_top_left, pix_bottom_left,
           pix_top_right, pix_bottom_right, dest_pixel, inside_req,
    output ready
  );
endinterface

interface bac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        written;

  modport source (output valid, out_pixel, written, input ready);
  modport sink   (input valid, out_pixel, written, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bilinear_alpha_composite.sv
`default_nettype none

// bilinear sample and alpha-over composite. each transaction on in_if carries
// the four source neighbours, q16 fractions in x and y, the destination pixel
// and an inside flag; one transaction leaves on out_if for each one taken.
// throughput is one pixel per clock while out_if is not stalled. the block is
// a 15-stage pipeline (weights, interpolation products, interpolation sum, cut
// compare and a1, blend products, blend sum, 8 stages of restoring division,
// output register); its length is set by the per-channel divider, which
// resolves one quotient bit per stage. a stall on out_if only holds the full
// stages: empty stages still close up, so in_if keeps taking transactions until
// the pipeline is full. the user must write the cut registers through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module bilinear_alpha_composite
  import bac_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bac_in_if.sink                    in_if,
  bac_out_if.source                 out_if,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  bac_byte_t low_cut_r;
  bac_byte_t high_cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cut_r  <= LOW_CUT_RST;
      high_cut_r <= HIGH_CUT_RST;
    end else if (cfg_we) begin
      unique case (bac_cfg_idx_t'(cfg_index))
        CFG_LOW_ALPHA_CUT:  low_cut_r  <= cfg_wdata;
        CFG_HIGH_ALPHA_CUT: high_cut_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control
  // a stage loads when it is empty or everything after it moves; written as a
  // per-stage test of "this stage and all later ones full" rather than a chain
  // ---------------------------------------------------------------------------
  bac_stage_t v_r;
  bac_stage_t en;

  always_comb begin
    for (int i = 1; i <= NUM_STAGES; i++) begin
      en[i] = out_if.ready ||
              !(&(v_r | ((bac_stage_t'(1) << (i - 1)) - bac_stage_t'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[STG_WGT]) begin
        v_r[STG_WGT] <= in_if.valid;
      end
      for (int i = STG_WGT + 1; i <= NUM_STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_if.ready  = en[STG_WGT];
  assign out_if.valid = v_r[STG_OUT];

  // ---------------------------------------------------------------------------
  // stage 1: bilinear weights
  // the inverse fractions are 17 bit since a zero fraction gives a full weight
  // ---------------------------------------------------------------------------
  logic [16:0] inv_u;
  logic [16:0] inv_v;
  logic [33:0] prod_tl;
  logic [32:0] prod_bl;
  logic [32:0] prod_tr;
  logic [31:0] prod_br;

  assign inv_u   = Q16_ONE - {1'b0, in_if.frac_x};
  assign inv_v   = Q16_ONE - {1'b0, in_if.frac_y};
  assign prod_tl = {17'd0, inv_u} * {17'd0, inv_v};
  assign prod_bl = {17'd0, in_if.frac_y} * {16'd0, inv_u};
  assign prod_tr = {17'd0, in_if.frac_x} * {16'd0, inv_v};
  assign prod_br = {16'd0, in_if.frac_x} * {16'd0, in_if.frac_y};

  bac_quad_weight_t wt_r;
  bac_pixel_t       px_r [NUM_CORNERS];
  bac_pixel_t       s1_dst_r;
  logic             s1_inside_r;

  always_ff @(posedge clk) begin
    if (en[STG_WGT]) begin
      wt_r[CRN_TL]  <= prod_tl[32:16];
      wt_r[CRN_BL]  <= prod_bl[32:16];
      wt_r[CRN_TR]  <= prod_tr[32:16];
      wt_r[CRN_BR]  <= {1'b0, prod_br[31:16]};
      px_r[CRN_TL]  <= in_if.pix_top_left;
      px_r[CRN_BL]  <= in_if.pix_bottom_left;
      px_r[CRN_TR]  <= in_if.pix_top_right;
      px_r[CRN_BR]  <= in_if.pix_bottom_right;
      s1_dst_r      <= in_if.dest_pixel;
      s1_inside_r   <= in_if.inside_req;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2-3: one interpolation lane per byte channel
  // ---------------------------------------------------------------------------
  bac_pixel_t smp_px;

  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_interp
    bac_quad_byte_t lane_pix;

    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
      assign lane_pix[c] = px_r[c][k];
    end

    bac_interp_lane u_interp (
      .clk     (clk),
      .en_prod (en[STG_PROD]),
      .en_sum  (en[STG_SMP]),
      .pix_i   (lane_pix),
      .wt_i    (wt_r),
      .smp_o   (smp_px[k])
    );
  end

  // destination and flag ride alongside the lanes
  bac_pixel_t s2_dst_r;
  bac_pixel_t s3_dst_r;
  logic       s2_inside_r;
  logic       s3_inside_r;

  always_ff @(posedge clk) begin
    if (en[STG_PROD]) begin
      s2_dst_r    <= s1_dst_r;
      s2_inside_r <= s1_inside_r;
    end
    if (en[STG_SMP]) begin
      s3_dst_r    <= s2_dst_r;
      s3_inside_r <= s2_inside_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: cut compare and destination share a1 = da*(256-a2) >> 8
  // ---------------------------------------------------------------------------
  bac_side_t  side_r [STG_CMP:STG_OUT-1];
  bac_side_t  cmp_side;
  bac_side_t  mul_side;
  logic [8:0] inv_a2;
  logic [16:0] a1_prod;
  bac_byte_t  a1_r;
  logic [8:0] a0;

  assign inv_a2  = ALPHA_ONE - {1'b0, smp_px[CH_ALPHA]};
  assign a1_prod = {9'd0, s3_dst_r[CH_ALPHA]} * {8'd0, inv_a2};

  always_comb begin
    cmp_side          = '0;
    cmp_side.sample   = smp_px;
    cmp_side.dest     = s3_dst_r;
    cmp_side.in_image = s3_inside_r;
    cmp_side.replace  = (s3_dst_r[CH_ALPHA] < low_cut_r) ||
                        (smp_px[CH_ALPHA] > high_cut_r);
  end

  // ---------------------------------------------------------------------------
  // stage 5: blended alpha a0 = a2 + a1; it stays below 256, so a byte holds it
  // a zero a0 only happens with a low cut of zero and gives a black pixel
  // ---------------------------------------------------------------------------
  assign a0 = {1'b0, side_r[STG_CMP].sample[CH_ALPHA]} + {1'b0, a1_r};

  always_comb begin
    mul_side       = side_r[STG_CMP];
    mul_side.alpha = a0[7:0];
    mul_side.zero  = (a0 == 9'd0);
  end

  always_ff @(posedge clk) begin
    if (en[STG_CMP]) begin
      side_r[STG_CMP] <= cmp_side;
      a1_r            <= a1_prod[15:8];
    end
    if (en[STG_MUL]) begin
      side_r[STG_MUL] <= mul_side;
    end
    for (int i = STG_SUM; i <= STG_OUT - 1; i++) begin
      if (en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 5-14: per colour channel, numerator then division by a0
  // ---------------------------------------------------------------------------
  bac_byte_t quo [NUM_COLOURS];

  for (genvar k = 0; k < NUM_COLOURS; k++) begin : g_colour
    logic [NUM_W-1:0] num;

    bac_blend_lane u_blend (
      .clk    (clk),
      .en_mul (en[STG_MUL]),
      .en_sum (en[STG_SUM]),
      .smp_i  (side_r[STG_CMP].sample[k]),
      .dst_i  (side_r[STG_CMP].dest[k]),
      .a2_i   (side_r[STG_CMP].sample[CH_ALPHA]),
      .a1_i   (a1_r),
      .num_o  (num)
    );

    bac_div_lane u_div (
      .clk   (clk),
      .en    (en[STG_OUT-1:STG_DIV0]),
      .num_i (num),
      .den_i (side_r[STG_SUM].alpha),
      .quo_o (quo[k])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 15: merge lanes and pick the result
  //   outside: destination passes, not written
  //   replace: the sample, alpha included
  //   zero blended alpha: black
  //   otherwise: blended colours under a0
  // ---------------------------------------------------------------------------
  bac_side_t   fin_side;
  logic [31:0] out_pixel_nxt;
  logic        written_nxt;
  logic [31:0] out_pixel_r;
  logic        written_r;

  assign fin_side = side_r[STG_OUT-1];

  always_comb begin
    written_nxt = fin_side.in_image;
    if (!fin_side.in_image) begin
      out_pixel_nxt = fin_side.dest;
    end else if (fin_side.replace) begin
      out_pixel_nxt = fin_side.sample;
    end else if (fin_side.zero) begin
      out_pixel_nxt = '0;
    end else begin
      out_pixel_nxt = {fin_side.alpha, quo[2], quo[1], quo[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_pixel_r <= out_pixel_nxt;
      written_r   <= written_nxt;
    end
  end

  assign out_if.out_pixel = out_pixel_r;
  assign out_if.written   = written_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // with the output stalled, a transaction is only taken if a bubble remains
  a_accept_needs_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STG_OUT] && !out_if.ready && in_if.ready) |-> !(&v_r))
    else $error("input taken into a full stalled pipeline");

  // reset leaves every stage empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (v_r == '0))
    else $error("pipeline not empty after reset");

  // blended alpha never falls below the sample alpha and never wraps
  a_blend_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STG_SUM] && side_r[STG_SUM].in_image && !side_r[STG_SUM].replace &&
     !side_r[STG_SUM].zero) |-> (side_r[STG_SUM].alpha >= side_r[STG_SUM].sample[CH_ALPHA]))
    else $error("blended alpha below sample alpha");

endmodule

`default_nettype wire

>>> hw/rtl/bac_interp_lane.sv
`default_nettype none

module bac_interp_lane
  import bac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en_prod,
  input  wire logic             en_sum,
  input  wire bac_quad_byte_t   pix_i,
  input  wire bac_quad_weight_t wt_i,
  output bac_byte_t             smp_o
);

  bac_quad_prod_t prod_r;
  logic [26:0]    sum;
  bac_byte_t      smp_r;

  always_ff @(posedge clk) begin
    if (en_prod) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        prod_r[c] <= {17'd0, pix_i[c]} * {8'd0, wt_i[c]};
      end
    end
  end

  assign sum = {2'd0, prod_r[CRN_TL]} + {2'd0, prod_r[CRN_BL]}
             + {2'd0, prod_r[CRN_TR]} + {2'd0, prod_r[CRN_BR]};

  // drop the q16 fraction, keep one byte
  always_ff @(posedge clk) begin
    if (en_sum) begin
      smp_r <= sum[23:16];
    end
  end

  assign smp_o = smp_r;

endmodule

`default_nettype wire

>>> hw/rtl/bac_blend_lane.sv
`default_nettype none

module bac_blend_lane
  import bac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en_mul,
  input  wire logic             en_sum,
  input  wire bac_byte_t        smp_i,
  input  wire bac_byte_t        dst_i,
  input  wire bac_byte_t        a2_i,
  input  wire bac_byte_t        a1_i,
  output logic [NUM_W-1:0]      num_o
);

  logic [15:0]      prod_s_r;
  logic [15:0]      prod_d_r;
  logic [16:0]      sum;
  logic [NUM_W-1:0] num_r;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_s_r <= {8'd0, smp_i} * {8'd0, a2_i};
      prod_d_r <= {8'd0, a1_i} * {8'd0, dst_i};
    end
  end

  // weighted sum is bounded by 255*a0, so the carry is always clear
  assign sum = {1'b0, prod_s_r} + {1'b0, prod_d_r};

  always_ff @(posedge clk) begin
    if (en_sum) begin
      num_r <= sum[NUM_W-1:0];
    end
  end

  assign num_o = num_r;

endmodule

`default_nettype wire

>>> hw/rtl/bac_div_lane.sv
`default_nettype none

module bac_div_lane
  import bac_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [DIV_STAGES-1:0] en,
  input  wire logic [NUM_W-1:0]      num_i,
  input  wire bac_byte_t             den_i,
  output bac_byte_t                  quo_o
);

  // restoring division, one quotient bit per stage, msb first
  bac_byte_t rem_r [DIV_STAGES-1];
  bac_byte_t low_r [DIV_STAGES-1];
  bac_byte_t den_r [DIV_STAGES-1];
  bac_byte_t quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    bac_byte_t  rem_in;
    bac_byte_t  low_in;
    bac_byte_t  den_in;
    bac_byte_t  quo_in;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       take;

    if (k == 0) begin : g_first
      // the quotient fits a byte, so the upper half starts below the divisor
      assign rem_in = num_i[NUM_W-1:8];
      assign low_in = num_i[7:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, low_in[7]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo_r[k] <= {quo_in[6:0], take};
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= take ? diff[7:0] : trial[7:0];
          low_r[k] <= {low_in[6:0], 1'b0};
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> verif/tb_bilinear_alpha_composite.sv
`timescale 1ns / 1ps

module tb_bilinear_alpha_composite;
  import bac_pkg::*;

  // ---------------------------------------------------------------------------
  // local types
  // ---------------------------------------------------------------------------

  // one destination pixel request as it travels on in_if
  typedef struct packed {
    logic [15:0] frac_x;
    logic [15:0] frac_y;
    bac_pixel_t  top_left;
    bac_pixel_t  bottom_left;
    bac_pixel_t  top_right;
    bac_pixel_t  bottom_right;
    bac_pixel_t  dest;
    logic        in_image;
  } pixel_req_t;

  // one composited pixel as it leaves on out_if
  typedef struct packed {
    bac_pixel_t pixel;
    logic       written;
  } pixel_res_t;

  // which branch of the composite a pixel took, for the closing summary
  typedef enum int {
    PATH_OUTSIDE,
    PATH_REPLACE,
    PATH_BLEND,
    PATH_ZERO_ALPHA,
    NUM_PATHS
  } pixel_path_t;

  // directed table row: cut settings, request and, where obvious, the answer
  typedef struct packed {
    bac_byte_t  low_cut;
    bac_byte_t  high_cut;
    pixel_req_t req;
    logic       has_result;
    pixel_res_t res;
  } directed_row_t;

  localparam int NUM_DIRECTED    = 20;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int MAX_REPORTS     = 10;

  // corner cases first at the reset cuts, then at the extreme cut settings
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // outside the source image: destination passes unchanged
    '{8'd5, 8'd250, '{16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'hDEADBEEF, 1'b0}, 1'b1, '{32'hDEADBEEF, 1'b0}},
    '{8'd5, 8'd250, '{16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      1'b1, '{32'h0, 1'b0}},
    // zero fractions pick top left; opaque sample above high cut replaces
    '{8'd5, 8'd250, '{16'h0000, 16'h0000, 32'hFF112233, 32'h0F0E0D0C, 32'h01020304,
      32'hA5A5A5A5, 32'h80000000, 1'b1}, 1'b1, '{32'hFF112233, 1'b1}},
    // destination alpha below low cut replaces
    '{8'd5, 8'd250, '{16'h0000, 16'h0000, 32'h7F445566, 32'h11111111, 32'h22222222,
      32'h33333333, 32'h04ABCDEF, 1'b1}, 1'b1, '{32'h7F445566, 1'b1}},
    // plain blend, then destination alpha equal to low cut, sample equal to high cut
    '{8'd5, 8'd250, '{16'h0000, 16'h0000, 32'h80402010, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'hFF000000, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd5, 8'd250, '{16'h0000, 16'h0000, 32'h80402010, 32'h0, 32'h0, 32'h0,
      32'h05FFFFFF, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd5, 8'd250, '{16'h0000, 16'h0000, 32'hFA806040, 32'h0, 32'h0, 32'h0,
      32'h80102030, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    // fraction extremes
    '{8'd5, 8'd250, '{16'hFFFF, 16'hFFFF, 32'h10203040, 32'h50607080, 32'h90A0B0C0,
      32'hD0E0F0FF, 32'hC0C0C0C0, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd5, 8'd250, '{16'hFFFF, 16'h0000, 32'h00000000, 32'hFFFFFFFF, 32'hFF00FF00,
      32'h00FF00FF, 32'h7F7F7F7F, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd5, 8'd250, '{16'h0000, 16'hFFFF, 32'h12345678, 32'hFEDCBA98, 32'h00000000,
      32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    // all-ones and all-zero neighbours at the centre
    '{8'd5, 8'd250, '{16'h8000, 16'h8000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'h80FF00FF, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd5, 8'd250, '{16'h8000, 16'h8000, 32'h0, 32'h0, 32'h0, 32'h0,
      32'hFFFFFFFF, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd5, 8'd250, '{16'h1234, 16'hABCD, 32'h9ABCDEF0, 32'h13579BDF, 32'h2468ACE0,
      32'h0F1E2D3C, 32'h60708090, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    // low cut 0, high cut 255: both alphas zero gives a zero pixel
    '{8'd0, 8'd255, '{16'h0000, 16'h0000, 32'h00FFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'h00123456, 1'b1}, 1'b1, '{32'h0, 1'b1}},
    '{8'd0, 8'd255, '{16'h0000, 16'h0000, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0,
      32'h00000000, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd0, 8'd255, '{16'hC000, 16'h4000, 32'h40302010, 32'h80706050, 32'hC0B0A090,
      32'hFFEEDDCC, 32'h00ABCDEF, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    // low cut 255, high cut 0: replace unless dest opaque and sample transparent
    '{8'd255, 8'd0, '{16'h0000, 16'h0000, 32'h00123456, 32'h0, 32'h0, 32'h0,
      32'hFE654321, 1'b1}, 1'b1, '{32'h00123456, 1'b1}},
    '{8'd255, 8'd0, '{16'h0000, 16'h0000, 32'h00ABCDEF, 32'h0, 32'h0, 32'h0,
      32'hFF102030, 1'b1}, 1'b0, '{32'h0, 1'b0}},
    '{8'd255, 8'd0, '{16'h0000, 16'h0000, 32'h01ABCDEF, 32'h0, 32'h0, 32'h0,
      32'hFF102030, 1'b1}, 1'b1, '{32'h01ABCDEF, 1'b1}},
    '{8'd255, 8'd0, '{16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'h12345678, 1'b0}, 1'b1, '{32'h12345678, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  bac_in_if  in_bus ();
  bac_out_if out_bus ();

  bilinear_alpha_composite i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // scoreboard state
  // ---------------------------------------------------------------------------
  pixel_res_t pixels_due [$];  // composited pixels still owed by the block, oldest first
  pixel_res_t oldest_due;
  bac_byte_t  low_cut;         // cut values the block holds right now
  bac_byte_t  high_cut;
  bit         idle_en;         // random gaps on both channels when set
  int         n_failures;
  int         n_checked;
  int         n_settings;
  int         path_count [NUM_PATHS];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: bilinear sample, then alpha-over composite
  // ---------------------------------------------------------------------------
  function automatic pixel_res_t composite_pixel(input pixel_req_t r, input bac_byte_t low,
                                                 input bac_byte_t high,
                                                 output pixel_path_t path);
    longint unsigned inv_x, inv_y, frac_x, frac_y, acc;
    longint unsigned weight [NUM_CORNERS];
    bac_pixel_t      corner [NUM_CORNERS];
    bac_pixel_t      smp;
    int unsigned     da, a2, a1, a0;
    pixel_res_t      res;
    int              ch, c;

    // outside the source image the destination is handed straight back
    if (!r.in_image) begin
      path = PATH_OUTSIDE;
      res.pixel   = r.dest;
      res.written = 1'b0;
      return res;
    end

    // q16 corner weights, each product truncated back to q16
    frac_x = longint'(r.frac_x);
    frac_y = longint'(r.frac_y);
    inv_x  = 64'd65536 - frac_x;
    inv_y  = 64'd65536 - frac_y;
    weight[CRN_TL] = (inv_x * inv_y) >> 16;
    weight[CRN_BL] = (frac_y * inv_x) >> 16;
    weight[CRN_TR] = (frac_x * inv_y) >> 16;
    weight[CRN_BR] = (frac_x * frac_y) >> 16;
    corner[CRN_TL] = r.top_left;
    corner[CRN_BL] = r.bottom_left;
    corner[CRN_TR] = r.top_right;
    corner[CRN_BR] = r.bottom_right;
    for (ch = 0; ch < NUM_CHANNELS; ch++) begin
      acc = 0;
      for (c = 0; c < NUM_CORNERS; c++) begin
        acc += longint'(corner[c][ch]) * weight[c];
      end
      smp[ch] = 8'(acc >> 16);
    end

    res.written = 1'b1;
    da = r.dest[CH_ALPHA];
    a2 = smp[CH_ALPHA];
    if (da < low || a2 > high) begin
      path = PATH_REPLACE;
      res.pixel = smp;
      return res;
    end

    a1 = (da * (256 - a2)) >> 8;
    a0 = a2 + a1;
    if (a0 == 0) begin
      path = PATH_ZERO_ALPHA;
      res.pixel = '0;
      return res;
    end

    path = PATH_BLEND;
    res.pixel[CH_ALPHA] = 8'(a0);
    for (ch = 0; ch < NUM_COLOURS; ch++) begin
      res.pixel[ch] = 8'((smp[ch] * a2 + a1 * r.dest[ch]) / a0);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, some medium, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] random_frac();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // an alpha at or one step either side of a cut
  function automatic bac_byte_t near_cut(input bac_byte_t cut);
    int v;
    v = int'(cut) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return bac_byte_t'(v);
  endfunction

  // random pixel, with alphas often steered onto the cut boundaries
  function automatic pixel_req_t random_pixel_req(input bac_byte_t low, input bac_byte_t high);
    pixel_req_t r;
    int         mode;
    bac_byte_t  sa;

    r.frac_x       = random_frac();
    r.frac_y       = random_frac();
    r.top_left     = $urandom;
    r.bottom_left  = $urandom;
    r.top_right    = $urandom;
    r.bottom_right = $urandom;
    r.dest         = $urandom;
    mode = $urandom_range(0, 3);
    // equal corner alphas keep the sample alpha close to the high cut
    if ((mode & 1) != 0) begin
      sa = near_cut(high);
      r.top_left[CH_ALPHA]     = sa;
      r.bottom_left[CH_ALPHA]  = sa;
      r.top_right[CH_ALPHA]    = sa;
      r.bottom_right[CH_ALPHA] = sa;
    end
    if ((mode & 2) != 0) r.dest[CH_ALPHA] = near_cut(low);
    r.in_image = ($urandom_range(0, 99) < 85);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver tasks, all called from the stimulus process at a rising edge
  // ---------------------------------------------------------------------------

  // write both cut registers once the pipeline has emptied
  task automatic set_cuts(input bac_byte_t low, input bac_byte_t high);
    in_bus.valid <= 1'b0;
    wait (pixels_due.size() == 0);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_ALPHA_CUT;
    cfg_wdata <= low;
    @(posedge clk);
    cfg_index <= CFG_HIGH_ALPHA_CUT;
    cfg_wdata <= high;
    @(posedge clk);
    cfg_we    <= 1'b0;
    low_cut  = low;
    high_cut = high;
    n_settings++;
  endtask

  // offer one request and hold it until the block takes the transaction
  task automatic send_pixel(input pixel_req_t r, input logic use_given,
                            input pixel_res_t given);
    int          gap;
    logic        taken;
    pixel_path_t path;
    pixel_res_t  predicted;

    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.frac_x           <= r.frac_x;
    in_bus.frac_y           <= r.frac_y;
    in_bus.pix_top_left     <= r.top_left;
    in_bus.pix_bottom_left  <= r.bottom_left;
    in_bus.pix_top_right    <= r.top_right;
    in_bus.pix_bottom_right <= r.bottom_right;
    in_bus.dest_pixel       <= r.dest;
    in_bus.inside_req       <= r.in_image;
    // ready is looked at mid-cycle, where nothing is changing
    do begin
      @(negedge clk);
      taken = in_bus.ready;
      @(posedge clk);
    end while (!taken);
    predicted = composite_pixel(r, low_cut, high_cut, path);
    path_count[path]++;
    pixels_due.push_back(use_given ? given : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int        i, p;
    bac_byte_t lo, hi;

    // every input known from time zero
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_LOW_ALPHA_CUT;
    cfg_wdata               <= '0;
    in_bus.valid            <= 1'b0;
    in_bus.frac_x           <= '0;
    in_bus.frac_y           <= '0;
    in_bus.pix_top_left     <= '0;
    in_bus.pix_bottom_left  <= '0;
    in_bus.pix_top_right    <= '0;
    in_bus.pix_bottom_right <= '0;
    in_bus.dest_pixel       <= '0;
    in_bus.inside_req       <= 1'b0;
    low_cut    = LOW_CUT_RST;
    high_cut   = HIGH_CUT_RST;
    idle_en    = 1'b1;
    n_failures = 0;
    n_checked  = 0;
    n_settings = 0;
    foreach (path_count[k]) path_count[k] = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the first rows run on the cut values out of reset
    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].low_cut != low_cut || DIRECTED_ROWS[i].high_cut != high_cut) begin
        set_cuts(DIRECTED_ROWS[i].low_cut, DIRECTED_ROWS[i].high_cut);
      end
      send_pixel(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].has_result, DIRECTED_ROWS[i].res);
    end

    // random phases: random cuts, both extremes, back to the reset values
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1:       begin lo = 8'd0;         hi = 8'd255;       end
        2:       begin lo = 8'd255;       hi = 8'd0;         end
        4:       begin lo = LOW_CUT_RST;  hi = HIGH_CUT_RST; end
        default: begin lo = 8'($urandom); hi = 8'($urandom); end
      endcase
      // one phase runs back to back at full rate with no gaps anywhere
      idle_en = (p != 2);
      set_cuts(lo, hi);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // mid-phase hold-off until the pipeline has drained completely
        if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
          in_bus.valid <= 1'b0;
          wait (pixels_due.size() == 0);
          @(posedge clk);
        end
        send_pixel(random_pixel_req(lo, hi), 1'b0, '0);
      end
    end

    // drain, then give stray transactions a chance to show up
    in_bus.valid <= 1'b0;
    wait (pixels_due.size() == 0);
    repeat (2 * NUM_STAGES) @(posedge clk);

    $display("checked %0d composited pixels across %0d cut settings",
             n_checked, n_settings);
    $display("paths taken: %0d blended, %0d replaced, %0d zero alpha, %0d outside",
             path_count[PATH_BLEND], path_count[PATH_REPLACE],
             path_count[PATH_ZERO_ALPHA], path_count[PATH_OUTSIDE]);
    if (n_failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure on out_if
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    int run, gap;
    forever begin
      out_bus.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every out_if transaction against the oldest pixel owed
  // ---------------------------------------------------------------------------
  function automatic void report_failure(input string msg);
    n_failures++;
    if (n_failures <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // sampled mid-cycle, the transaction completes at the following rising edge
  always @(negedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pixels_due.size() == 0) begin
        report_failure($sformatf("pixel %h written %b with nothing outstanding",
                                 out_bus.out_pixel, out_bus.written));
      end else begin
        oldest_due = pixels_due.pop_front();
        n_checked++;
        if (out_bus.out_pixel !== oldest_due.pixel) begin
          report_failure($sformatf("out_pixel expected %h got %h",
                                   oldest_due.pixel, out_bus.out_pixel));
        end
        if (out_bus.written !== oldest_due.written) begin
          report_failure($sformatf("written expected %b got %b (pixel %h)",
                                   oldest_due.written, out_bus.written,
                                   oldest_due.pixel));
        end
      end
    end
  end

endmodule
